// ----- rtl/core/rpp_pkg.sv -----
package rpp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = 2;
  localparam int unsigned QCNT_BITS   = 3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5a;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_LEAD0  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_ERROR  = 2'd3
  } rpp_phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2
  } rpp_radix_t;

  // Classified character as it passes from front to back.
  typedef struct packed {
    logic       term;
    logic       blank;
    logic       zero;
    logic       pfx_x;
    logic       pfx_b;
    logic       dig_ok;
    logic [3:0] dig;
  } rpp_tok_t;

endpackage

// ----- rtl/core/rpp_front.sv -----
module rpp_front (
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] char_code
  input  logic            q_full,
  output logic            push,
  output rpp_pkg::rpp_tok_t tok
);

  logic [7:0] lc;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    lc = s_tdata;
    if (s_tdata >= rpp_pkg::CH_UC_A && s_tdata <= rpp_pkg::CH_UC_Z) begin
      lc = s_tdata | rpp_pkg::CASE_BIT;
    end
    tok.term   = (s_tdata == rpp_pkg::CH_NUL);
    tok.blank  = (s_tdata == rpp_pkg::CH_SPACE) || (s_tdata == rpp_pkg::CH_TAB);
    tok.zero   = (s_tdata == rpp_pkg::CH_ZERO);
    tok.pfx_x  = (lc == rpp_pkg::CH_LC_X);
    tok.pfx_b  = (lc == rpp_pkg::CH_LC_B);
    tok.dig_ok = 1'b0;
    tok.dig    = 4'd0;
    if (lc >= rpp_pkg::CH_ZERO && lc <= rpp_pkg::CH_NINE) begin
      tok.dig_ok = 1'b1;
      tok.dig    = 4'(lc - rpp_pkg::CH_ZERO);
    end else if (lc >= rpp_pkg::CH_LC_A && lc <= rpp_pkg::CH_LC_F) begin
      tok.dig_ok = 1'b1;
      tok.dig    = 4'(lc - rpp_pkg::CH_LC_A + 8'd10);
    end
  end

endmodule

// ----- rtl/core/rpp_queue.sv -----
module rpp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rpp_pkg::rpp_tok_t push_tok,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output rpp_pkg::rpp_tok_t q_tok
);

  rpp_pkg::rpp_tok_t mem [rpp_pkg::QUEUE_DEPTH];
  logic [rpp_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [rpp_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [rpp_pkg::QCNT_BITS-1:0] count;

  function automatic logic [rpp_pkg::QCNT_BITS-1:0] QCNT_BITS_ONE(input logic b);
    return {{(rpp_pkg::QCNT_BITS-1){1'b0}}, b};
  endfunction

  assign full    = (count == rpp_pkg::QCNT_BITS'(rpp_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_tok   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_BITS_ONE(push) - QCNT_BITS_ONE(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> !pop) else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= rpp_pkg::QCNT_BITS'(rpp_pkg::QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// ----- rtl/core/rpp_back.sv -----
module rpp_back #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  rpp_pkg::rpp_tok_t     q_tok,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [VALUE_BITS-1:0] out_value,
  output logic                  out_ok
);

  rpp_pkg::rpp_phase_t   phase, phase_next;
  rpp_pkg::rpp_radix_t   radix, radix_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic                  any_digit, any_digit_next;
  logic                  good;
  logic                  dig_in_base;
  logic [VALUE_BITS-1:0] dig_ext;
  logic [VALUE_BITS-1:0] acc_step;

  assign pop     = q_valid && (!q_tok.term || !m_tvalid || m_tready);
  assign dig_ext = {{(VALUE_BITS-4){1'b0}}, q_tok.dig};
  assign good    = (phase != rpp_pkg::PH_ERROR) &&
                   ((phase == rpp_pkg::PH_LEAD0) || any_digit);

  always_comb begin
    unique case (radix)
      rpp_pkg::RX_HEX: begin
        dig_in_base = q_tok.dig_ok;
        acc_step    = (acc << 4) + dig_ext;
      end
      rpp_pkg::RX_BIN: begin
        dig_in_base = q_tok.dig_ok && (q_tok.dig < 4'd2);
        acc_step    = (acc << 1) + dig_ext;
      end
      default: begin
        dig_in_base = q_tok.dig_ok && (q_tok.dig < 4'd10);
        acc_step    = (acc << 3) + (acc << 1) + dig_ext;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= rpp_pkg::PH_SKIP;
      radix     <= rpp_pkg::RX_DEC;
      acc       <= '0;
      any_digit <= 1'b0;
    end else if (pop) begin
      phase     <= phase_next;
      radix     <= radix_next;
      acc       <= acc_next;
      any_digit <= any_digit_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    radix_next     = radix;
    acc_next       = acc;
    any_digit_next = any_digit;
    if (q_tok.term) begin
      phase_next     = rpp_pkg::PH_SKIP;
      radix_next     = rpp_pkg::RX_DEC;
      acc_next       = '0;
      any_digit_next = 1'b0;
    end else begin
      unique case (phase)
        rpp_pkg::PH_SKIP: begin
          if (q_tok.blank) begin
            phase_next = rpp_pkg::PH_SKIP;
          end else if (q_tok.zero) begin
            phase_next = rpp_pkg::PH_LEAD0;
          end else if (dig_in_base) begin
            acc_next       = acc_step;
            any_digit_next = 1'b1;
            phase_next     = rpp_pkg::PH_DIGITS;
          end else begin
            phase_next = rpp_pkg::PH_ERROR;
          end
        end
        rpp_pkg::PH_LEAD0: begin
          acc_next   = '0;
          phase_next = rpp_pkg::PH_DIGITS;
          if (q_tok.pfx_x) begin
            radix_next     = rpp_pkg::RX_HEX;
            any_digit_next = 1'b0;
          end else if (q_tok.pfx_b) begin
            radix_next     = rpp_pkg::RX_BIN;
            any_digit_next = 1'b0;
          end else begin
            // leading zero was a decimal digit; accumulator is still zero
            radix_next     = rpp_pkg::RX_DEC;
            any_digit_next = 1'b1;
            if (q_tok.dig_ok && (q_tok.dig < 4'd10)) begin
              acc_next = dig_ext;
            end else begin
              phase_next = rpp_pkg::PH_ERROR;
            end
          end
        end
        rpp_pkg::PH_DIGITS: begin
          if (dig_in_base) begin
            acc_next       = acc_step;
            any_digit_next = 1'b1;
          end else begin
            phase_next = rpp_pkg::PH_ERROR;
          end
        end
        default: begin
          phase_next = rpp_pkg::PH_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && q_tok.term) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_tok.term) begin
      out_value <= good ? acc : '0;
      out_ok    <= good;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_ok) |-> (out_value == '0)) else $error("failed parse with nonzero value");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && q_tok.term) |=> (phase == rpp_pkg::PH_SKIP) && (acc == '0) && !any_digit)
    else $error("state not cleared after terminator");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(pop && q_tok.term)) else $error("result overwritten");

endmodule

// ----- rtl/core/radix_prefixed_number_parser.sv -----
// Result path: a terminator passes through the queue; when the back end pops it, m_tvalid
// and its result word are registered together and held until taken.
// Throughput: one character per cycle while the queue is not full; the back end stalls only on a terminator
// while the output register still holds an untaken result.
// A four-entry queue between classifier and parse engine absorbs output stalls.
// Reset (rst, synchronous, active high) empties the queue, drops any pending
// result and returns the parser to blank skipping in decimal.
module radix_prefixed_number_parser #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] char_code
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0]     m_tdata,   // [VALUE_BITS-1:0] value, rest zero
  output logic                                m_tuser    // [0] ok
);

  localparam int unsigned TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

  rpp_pkg::rpp_tok_t     push_tok;
  rpp_pkg::rpp_tok_t     q_tok;
  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  q_valid;
  logic [VALUE_BITS-1:0] out_value;

  rpp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (full),
    .push     (push),
    .tok      (push_tok)
  );

  rpp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok)
  );

  rpp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_tok     (q_tok),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_value (out_value),
    .out_ok    (m_tuser)
  );

  assign m_tdata = TDATA_BITS'(out_value);

endmodule
